/* rtl/gps_pkg.sv */
// gradient position scaler: shared types, widths and codes
`default_nettype none
package gps_pkg;

   localparam int COORD_BITS = 8;
   localparam int LEVEL_BITS = 8;
   localparam int CSR_BITS   = 8;
   localparam int IDX_BITS   = 3;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int SQ_BITS    = 2 * COORD_BITS + 2;

   localparam logic [IDX_BITS-1:0] CSR_START_X     = 3'd0;
   localparam logic [IDX_BITS-1:0] CSR_START_Y     = 3'd1;
   localparam logic [IDX_BITS-1:0] CSR_END_X       = 3'd2;
   localparam logic [IDX_BITS-1:0] CSR_END_Y       = 3'd3;
   localparam logic [IDX_BITS-1:0] CSR_GRAD_MODE   = 3'd4;
   localparam logic [IDX_BITS-1:0] CSR_LEVEL_COUNT = 3'd5;

   localparam logic [1:0] MODE_LINEAR   = 2'd0;
   localparam logic [1:0] MODE_RADIAL   = 2'd1;
   localparam logic [1:0] MODE_BILINEAR = 2'd2;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      logic                  degenerate;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] end_x;
      logic [COORD_BITS-1:0] end_y;
      logic [1:0]            grad_mode;
      logic [LEVEL_BITS-1:0] level_count;
   } cfg_type;

   typedef struct packed {
      logic degenerate;
      logic full;
      logic radial;
   } flag_type;

endpackage
`default_nettype wire

/* rtl/gps_front.sv */
// gradient position scaler: differences, products and ratio operands
`default_nettype none
module gps_front (
   input  wire               clock,
   input  wire               reset,
   input  wire               advance,
   input  wire               in_valid,
   input  gps_pkg::req_type  in_item,
   input  gps_pkg::cfg_type  cfg,
   output logic              out_valid,
   output gps_pkg::flag_type out_flags,
   output logic [gps_pkg::SQ_BITS-1:0] out_num,
   output logic [gps_pkg::SQ_BITS-1:0] out_den
);
   import gps_pkg::*;

   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int SUM_BITS  = PROD_BITS + 1;

   logic                        a_v_ff;
   logic signed [DIFF_BITS-1:0] dx_ff, dy_ff, rx_ff, ry_ff;
   logic signed [DIFF_BITS-1:0] dx_in, dy_in, rx_in, ry_in;

   logic                        b_v_ff;
   logic signed [PROD_BITS-1:0] pdx_ff, pdy_ff, ptx_ff, pty_ff, prx_ff, pry_ff;

   logic signed [SUM_BITS-1:0]  l2_s, t_s, r2_s, tneg_s;
   logic [SQ_BITS-1:0]          l2_w, r2_w, mag_w, num_w;
   logic                        full_w;

   logic                        c_v_ff;
   flag_type                    flags_ff, flags_in;
   logic [SQ_BITS-1:0]          num_ff, num_in, den_ff;

   assign dx_in = $signed({1'b0, cfg.end_x})     - $signed({1'b0, cfg.start_x});
   assign dy_in = $signed({1'b0, cfg.end_y})     - $signed({1'b0, cfg.start_y});
   assign rx_in = $signed({1'b0, in_item.pixel_x}) - $signed({1'b0, cfg.start_x});
   assign ry_in = $signed({1'b0, in_item.pixel_y}) - $signed({1'b0, cfg.start_y});

   always_comb begin
      l2_s   = SUM_BITS'(pdx_ff) + SUM_BITS'(pdy_ff);
      t_s    = SUM_BITS'(ptx_ff) + SUM_BITS'(pty_ff);
      r2_s   = SUM_BITS'(prx_ff) + SUM_BITS'(pry_ff);
      tneg_s = -t_s;
      l2_w   = SQ_BITS'(l2_s);
      r2_w   = SQ_BITS'(r2_s);
      // a projection before the start counts as zero unless mirrored
      if (t_s < 0) begin
         mag_w = (cfg.grad_mode == MODE_BILINEAR) ? SQ_BITS'(tneg_s) : '0;
      end else begin
         mag_w = SQ_BITS'(t_s);
      end
      num_w  = (cfg.grad_mode == MODE_RADIAL) ? r2_w : mag_w;
      full_w = (num_w >= l2_w);
      flags_in.degenerate = (l2_w == '0);
      flags_in.full       = full_w;
      flags_in.radial     = (cfg.grad_mode == MODE_RADIAL);
      num_in = full_w ? '0 : num_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else if (advance) begin
         a_v_ff <= in_valid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         rx_ff    <= rx_in;
         ry_ff    <= ry_in;
         pdx_ff   <= dx_ff * dx_ff;
         pdy_ff   <= dy_ff * dy_ff;
         ptx_ff   <= rx_ff * dx_ff;
         pty_ff   <= ry_ff * dy_ff;
         prx_ff   <= rx_ff * rx_ff;
         pry_ff   <= ry_ff * ry_ff;
         flags_ff <= flags_in;
         num_ff   <= num_in;
         den_ff   <= l2_w;
      end
   end

   assign out_valid = c_v_ff;
   assign out_flags = flags_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;

endmodule
`default_nettype wire

/* rtl/gps_divider.sv */
// gradient position scaler: pipelined restoring fraction divider, one bit a stage
`default_nettype none
module gps_divider #(
   parameter int FRAC_BITS = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               advance,
   input  wire               in_valid,
   input  gps_pkg::flag_type in_flags,
   input  wire [gps_pkg::SQ_BITS-1:0] in_num,
   input  wire [gps_pkg::SQ_BITS-1:0] in_den,
   output logic              out_valid,
   output gps_pkg::flag_type out_flags,
   output logic [2*FRAC_BITS-1:0] out_quot
);
   import gps_pkg::*;

   localparam int STEPS = 2 * FRAC_BITS;
   localparam int QW    = 2 * FRAC_BITS;

   logic                v_ff     [STEPS];
   flag_type            flags_ff [STEPS];
   logic [SQ_BITS-1:0]  rem_ff   [STEPS];
   logic [SQ_BITS-1:0]  den_ff   [STEPS];
   logic [QW-1:0]       quot_ff  [STEPS];
   logic [SQ_BITS-1:0]  rem_in   [STEPS];
   logic [QW-1:0]       quot_in  [STEPS];

   genvar i;
   generate
      for (i = 0; i < STEPS; i++) begin : g_step
         logic               v_prev;
         flag_type           f_prev;
         logic [SQ_BITS-1:0] rem_prev, den_prev;
         logic [QW-1:0]      quot_prev;
         logic [SQ_BITS:0]   shifted;
         logic               take;

         if (i == 0) begin : g_first
            assign v_prev    = in_valid;
            assign f_prev    = in_flags;
            assign rem_prev  = in_num;
            assign den_prev  = in_den;
            assign quot_prev = '0;
         end else begin : g_next
            assign v_prev    = v_ff[i-1];
            assign f_prev    = flags_ff[i-1];
            assign rem_prev  = rem_ff[i-1];
            assign den_prev  = den_ff[i-1];
            assign quot_prev = quot_ff[i-1];
         end

         always_comb begin
            shifted    = {rem_prev, 1'b0};
            take       = (shifted >= {1'b0, den_prev});
            rem_in[i]  = take ? SQ_BITS'(shifted - {1'b0, den_prev}) : SQ_BITS'(shifted);
            quot_in[i] = {quot_prev[QW-2:0], take};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[i] <= 1'b0;
            end else if (advance) begin
               v_ff[i] <= v_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               flags_ff[i] <= f_prev;
               rem_ff[i]   <= rem_in[i];
               den_ff[i]   <= den_prev;
               quot_ff[i]  <= quot_in[i];
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[STEPS-1];
   assign out_flags = flags_ff[STEPS-1];
   assign out_quot  = quot_ff[STEPS-1];

endmodule
`default_nettype wire

/* rtl/gps_sqrt.sv */
// gradient position scaler: pipelined digit-by-digit square root, one root bit a stage
`default_nettype none
module gps_sqrt #(
   parameter int FRAC_BITS = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               advance,
   input  wire               in_valid,
   input  gps_pkg::flag_type in_flags,
   input  wire [2*FRAC_BITS-1:0] in_quot,
   output logic              out_valid,
   output gps_pkg::flag_type out_flags,
   output logic [FRAC_BITS-1:0] out_ratio
);
   import gps_pkg::*;

   localparam int F  = FRAC_BITS;
   localparam int VW = 2 * FRAC_BITS;
   localparam int RW = FRAC_BITS + 2;

   logic          v_ff     [F];
   flag_type      flags_ff [F];
   logic [VW-1:0] val_ff   [F];
   logic [RW-1:0] rem_ff   [F];
   logic [F-1:0]  root_ff  [F];
   logic [F-1:0]  lin_ff   [F];
   logic [RW-1:0] rem_in   [F];
   logic [F-1:0]  root_in  [F];

   genvar i;
   generate
      for (i = 0; i < F; i++) begin : g_step
         logic          v_prev;
         flag_type      f_prev;
         logic [VW-1:0] val_prev;
         logic [RW-1:0] rem_prev;
         logic [F-1:0]  root_prev, lin_prev;
         logic [RW:0]   partial, trial;
         logic          take;

         if (i == 0) begin : g_first
            assign v_prev    = in_valid;
            assign f_prev    = in_flags;
            assign val_prev  = in_quot;
            assign rem_prev  = '0;
            assign root_prev = '0;
            // linear ratio is the upper half of the doubled-precision quotient
            assign lin_prev  = in_quot[VW-1:F];
         end else begin : g_next
            assign v_prev    = v_ff[i-1];
            assign f_prev    = flags_ff[i-1];
            assign val_prev  = val_ff[i-1];
            assign rem_prev  = rem_ff[i-1];
            assign root_prev = root_ff[i-1];
            assign lin_prev  = lin_ff[i-1];
         end

         always_comb begin
            partial    = {rem_prev[RW-2:0], val_prev[VW-1:VW-2]};
            trial      = {1'b0, root_prev, 2'b01};
            take       = (partial >= trial);
            rem_in[i]  = take ? RW'(partial - trial) : RW'(partial);
            root_in[i] = {root_prev[F-2:0], take};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[i] <= 1'b0;
            end else if (advance) begin
               v_ff[i] <= v_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               flags_ff[i] <= f_prev;
               val_ff[i]   <= {val_prev[VW-3:0], 2'b00};
               rem_ff[i]   <= rem_in[i];
               root_ff[i]  <= root_in[i];
               lin_ff[i]   <= lin_prev;
            end
         end
      end
   endgenerate

   assign out_valid = v_ff[F-1];
   assign out_flags = flags_ff[F-1];
   assign out_ratio = flags_ff[F-1].radial ? root_ff[F-1] : lin_ff[F-1];

endmodule
`default_nettype wire

/* rtl/gps_scale.sv */
// gradient position scaler: level scaling, rounding and saturation
`default_nettype none
module gps_scale #(
   parameter int FRAC_BITS = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               advance,
   input  wire               in_valid,
   input  gps_pkg::flag_type in_flags,
   input  wire [FRAC_BITS-1:0] in_ratio,
   input  wire [gps_pkg::LEVEL_BITS-1:0] level_count,
   output logic              out_valid,
   output gps_pkg::rsp_type  out_item
);
   import gps_pkg::*;

   localparam int PW = LEVEL_BITS + FRAC_BITS;

   logic          p_v_ff;
   flag_type      p_flags_ff;
   logic [PW-1:0] prod_ff;

   logic [PW:0]           rounded;
   logic [LEVEL_BITS:0]   scaled;
   rsp_type               item_in;

   logic    o_v_ff;
   rsp_type item_ff;

   always_comb begin
      rounded = {1'b0, prod_ff} + ((PW+1)'(1) << (FRAC_BITS - 1));
      scaled  = rounded[PW:FRAC_BITS];
      item_in.degenerate = p_flags_ff.degenerate;
      priority if (p_flags_ff.degenerate) begin
         item_in.level = '0;
      end else if (p_flags_ff.full || scaled > {1'b0, level_count}) begin
         item_in.level = level_count;
      end else begin
         item_in.level = scaled[LEVEL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else if (advance) begin
         p_v_ff <= in_valid;
         o_v_ff <= p_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_flags_ff <= in_flags;
         prod_ff    <= PW'(level_count) * PW'(in_ratio);
         item_ff    <= item_in;
      end
   end

   assign out_valid = o_v_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

/* rtl/gradient_position_scaler.sv */
// gradient position scaler: top level with configuration registers and pipeline
`default_nettype none
// Maps one pixel coordinate per item to a gradient level between 0 and
// level_count along the line from the start point to the end point (linear
// clamped, radial or mirrored bilinear). Items enter at one per cycle while
// the output is not stalled and leave in order: three front stages form the
// differences, products and sums, then a restoring divider makes one
// quotient bit per stage over 2*FRAC_BITS stages, a square root stage chain
// makes one root bit per stage over FRAC_BITS stages, and two stages scale,
// round and saturate. The whole pipeline holds while a result waits on
// rsp_ready. Coincident start and end points give level 0 with degenerate
// set. The user must write configuration only while no item is in flight;
// the block itself does not enforce this.
module gradient_position_scaler #(
   parameter int FRAC_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  gps_pkg::req_type             req,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output gps_pkg::rsp_type             rsp,
   input  wire                          csr_we,
   input  wire [gps_pkg::IDX_BITS-1:0]  csr_index,
   input  wire [gps_pkg::CSR_BITS-1:0]  csr_wdata
);
   import gps_pkg::*;

   cfg_type cfg_ff;
   logic    advance;

   logic                 f_valid;
   flag_type             f_flags;
   logic [SQ_BITS-1:0]   f_num, f_den;
   logic                 d_valid;
   flag_type             d_flags;
   logic [2*FRAC_BITS-1:0] d_quot;
   logic                 s_valid;
   flag_type             s_flags;
   logic [FRAC_BITS-1:0] s_ratio;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_X:     cfg_ff.start_x     <= csr_wdata[COORD_BITS-1:0];
            CSR_START_Y:     cfg_ff.start_y     <= csr_wdata[COORD_BITS-1:0];
            CSR_END_X:       cfg_ff.end_x       <= csr_wdata[COORD_BITS-1:0];
            CSR_END_Y:       cfg_ff.end_y       <= csr_wdata[COORD_BITS-1:0];
            CSR_GRAD_MODE:   cfg_ff.grad_mode   <= csr_wdata[1:0];
            CSR_LEVEL_COUNT: cfg_ff.level_count <= csr_wdata[LEVEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   gps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_item   (req),
      .cfg       (cfg_ff),
      .out_valid (f_valid),
      .out_flags (f_flags),
      .out_num   (f_num),
      .out_den   (f_den)
   );

   gps_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (f_valid),
      .in_flags  (f_flags),
      .in_num    (f_num),
      .in_den    (f_den),
      .out_valid (d_valid),
      .out_flags (d_flags),
      .out_quot  (d_quot)
   );

   gps_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (d_valid),
      .in_flags  (d_flags),
      .in_quot   (d_quot),
      .out_valid (s_valid),
      .out_flags (s_flags),
      .out_ratio (s_ratio)
   );

   gps_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (s_valid),
      .in_flags    (s_flags),
      .in_ratio    (s_ratio),
      .level_count (cfg_ff.level_count),
      .out_valid   (rsp_valid),
      .out_item    (rsp)
   );

endmodule
`default_nettype wire

/* rtl/gps_checker.sv */
// gradient position scaler: port-level checks and their binding
`default_nettype none
module gps_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_ready,
   input wire              rsp_valid,
   input wire              rsp_ready,
   input gps_pkg::rsp_type rsp
);
   import gps_pkg::*;

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("result changed while stalled");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.degenerate |-> rsp.level == '0)
      else $error("degenerate item with nonzero level");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input side stalls only while a result is stuck
   a_ready_link: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input stalled without output backpressure");

endmodule

bind gradient_position_scaler gps_checker u_gps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);
`default_nettype wire
